@@ sv/zscore_q6p10_quantizer_unit_macros.svh @@
// Assertion helpers used by zsq_back.sv.
`ifndef ZSCORE_Q6P10_QUANTIZER_UNIT_MACROS_SVH
`define ZSCORE_Q6P10_QUANTIZER_UNIT_MACROS_SVH

// cond must hold at every clock outside reset
`define ZSQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ZSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/zsq_pkg.sv @@
`default_nettype none
package zsq_pkg;

  localparam int NUM_SLOTS = 7;
  localparam int RAW_W     = 32;
  localparam int Q_W       = 16;
  localparam int IN_W      = NUM_SLOTS * RAW_W;
  localparam int OUT_W     = NUM_SLOTS * Q_W;
  localparam int EXP_W     = 12;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    CLS_FINITE,
    CLS_INF,
    CLS_NAN
  } cls_t;

  typedef struct packed {
    logic                             valid;
    logic [IN_W-1:0]                  data;
    cls_t [NUM_SLOTS-1:0]             cls;
  } item_t;

  localparam logic [63:0] MEAN_TAB [NUM_SLOTS] = '{
    $realtobits(591.4182045417623),
    $realtobits(1.2184900023224592),
    $realtobits(0.5947851603496672),
    $realtobits(0.0005838004451228998),
    $realtobits(-0.8538870838842224),
    $realtobits(0.0027806010304868706),
    $realtobits(1824750.1096800924)
  };

  localparam logic [63:0] INV_SD_TAB [NUM_SLOTS] = '{
    $realtobits(0.0043363160471822084),
    $realtobits(10.80064871230099),
    $realtobits(0.0040239240828261573),
    $realtobits(22.283248685592664),
    $realtobits(1.3030990417413308),
    $realtobits(774.10332505181805),
    $realtobits(5.5184347675533539e-07)
  };

  function automatic logic [63:0] mean_bits(input logic [2:0] idx);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (idx == 3'(k)) r = MEAN_TAB[k];
    end
    return r;
  endfunction

  function automatic logic [63:0] inv_bits(input logic [2:0] idx);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (idx == 3'(k)) r = INV_SD_TAB[k];
    end
    return r;
  endfunction

  function automatic cls_t classify(input logic [RAW_W-1:0] raw);
    cls_t c;
    if (raw[30:23] != 8'hFF) c = CLS_FINITE;
    else if (raw[22:0] == 23'd0) c = CLS_INF;
    else c = CLS_NAN;
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/zsq_front.sv @@
`default_nettype none
module zsq_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [zsq_pkg::IN_W-1:0] in_tdata,
  output zsq_pkg::item_t             head,
  input  wire logic                  pop
);
  import zsq_pkg::*;

  logic [IN_W-1:0]            data_mem [2];
  cls_t [NUM_SLOTS-1:0]       cls_mem  [2];
  logic                       wptr_r, wptr_nxt;
  logic                       rptr_r, rptr_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  cls_t [NUM_SLOTS-1:0]       cls_in;
  logic                       push;

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      cls_in[k] = classify(in_tdata[k*RAW_W +: RAW_W]);
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_mem[wptr_r] <= in_tdata;
      cls_mem[wptr_r]  <= cls_in;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.data  = data_mem[rptr_r];
  assign head.cls   = cls_mem[rptr_r];

endmodule
`default_nettype wire

@@ sv/zsq_fp_pipe.sv @@
`default_nettype none
module zsq_fp_pipe (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [2:0]                 in_idx,
  input  wire logic [zsq_pkg::RAW_W-1:0]  in_raw,
  input  wire zsq_pkg::cls_t              in_cls,
  output logic                            out_valid,
  output logic [2:0]                      out_idx,
  output logic signed [zsq_pkg::Q_W-1:0]  out_q
);
  import zsq_pkg::*;

  typedef struct packed {
    logic       valid;
    logic [2:0] idx;
    cls_t       cls;
    logic       xs;
  } side_t;

  side_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r;

  // stage 1: unpack and align
  logic [7:0]               xe;
  logic [52:0]              xsig, msig, a_sig, b_sig;
  logic signed [EXP_W-1:0]  xexp, mexp, a_exp, b_exp, sh_full;
  logic [63:0]              mbits;
  logic                     bsign, x_big;
  logic [5:0]               sh;
  logic [111:0]             wide;
  logic [55:0]              a56_nxt, b56_nxt;
  logic [55:0]              a56_r, b56_r;
  logic                     asgn_r, sub_r;
  logic signed [EXP_W-1:0]  e1_r;

  always_comb begin
    xe    = in_raw[30:23];
    xsig  = {(xe != 8'd0), in_raw[22:0], 29'd0};
    xexp  = $signed({4'd0, (xe == 8'd0) ? 8'd1 : xe}) - 12'sd179;
    mbits = mean_bits(in_idx);
    msig  = {1'b1, mbits[51:0]};
    mexp  = $signed({1'b0, mbits[62:52]}) - 12'sd1075;
    bsign = ~mbits[63];
    x_big = (xexp >= mexp);
    a_sig = x_big ? xsig : msig;
    b_sig = x_big ? msig : xsig;
    a_exp = x_big ? xexp : mexp;
    b_exp = x_big ? mexp : xexp;
    sh_full = a_exp - b_exp;
    sh    = (sh_full > 12'sd56) ? 6'd56 : sh_full[5:0];
    wide  = {b_sig, 3'd0, 56'd0} >> sh;
    a56_nxt = {a_sig, 3'd0};
    b56_nxt = {wide[111:57], wide[56] | (|wide[55:0])};
  end

  always_ff @(posedge clk) begin
    a56_r  <= a56_nxt;
    b56_r  <= b56_nxt;
    asgn_r <= x_big ? in_raw[31] : bsign;
    sub_r  <= in_raw[31] ^ bsign;
    e1_r   <= a_exp;
  end

  // stage 2: add or subtract
  logic [56:0]             diff, sum, mag_nxt, mag_r;
  logic                    sgn_nxt, sgn2_r;
  logic signed [EXP_W-1:0] e2_r;

  always_comb begin
    diff = {1'b0, a56_r} - {1'b0, b56_r};
    sum  = {1'b0, a56_r} + {1'b0, b56_r};
    if (sub_r) begin
      if (diff[56]) begin
        mag_nxt = 57'd0 - diff;
        sgn_nxt = ~asgn_r;
      end else begin
        mag_nxt = diff;
        sgn_nxt = asgn_r;
      end
    end else begin
      mag_nxt = sum;
      sgn_nxt = asgn_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    sgn2_r <= sgn_nxt;
    e2_r   <= e1_r;
  end

  // stage 3: normalize
  logic [5:0]              lz;
  logic                    found;
  logic [56:0]             norm_r;
  logic signed [EXP_W-1:0] e3_r;
  logic                    sgn3_r, zero3_r;

  always_comb begin
    lz    = 6'd0;
    found = 1'b0;
    for (int i = 56; i >= 0; i--) begin
      if (!found && mag_r[i]) begin
        lz    = 6'(56 - i);
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    norm_r  <= mag_r << lz;
    e3_r    <= e2_r + 12'sd1 - $signed({6'd0, lz});
    sgn3_r  <= sgn2_r;
    zero3_r <= (mag_r == 57'd0);
  end

  // stage 4: round difference to binary64
  logic [53:0]             rd;
  logic                    up4;
  logic [52:0]             dsig_r;
  logic signed [EXP_W-1:0] de_r;
  logic                    sgn4_r, zero4_r;

  always_comb begin
    up4 = norm_r[3] & ((|norm_r[2:0]) | norm_r[4]);
    rd  = {1'b0, norm_r[56:4]} + {53'd0, up4};
  end

  always_ff @(posedge clk) begin
    dsig_r  <= rd[53] ? {1'b1, 52'd0} : rd[52:0];
    de_r    <= rd[53] ? e3_r + 12'sd1 : e3_r;
    sgn4_r  <= sgn3_r;
    zero4_r <= zero3_r;
  end

  // stage 5: partial products
  logic [63:0]             ibits;
  logic [52:0]             isig;
  logic signed [EXP_W-1:0] iexp;
  logic [51:0]             hh_r;
  logic [52:0]             hl_r, lh_r;
  logic [53:0]             ll_r;
  logic signed [EXP_W-1:0] pe5_r;
  logic                    sgn5_r, zero5_r;

  always_comb begin
    ibits = inv_bits(s4_r.idx);
    isig  = {1'b1, ibits[51:0]};
    iexp  = $signed({1'b0, ibits[62:52]}) - 12'sd1075;
  end

  always_ff @(posedge clk) begin
    hh_r    <= dsig_r[52:27] * isig[52:27];
    hl_r    <= dsig_r[52:27] * isig[26:0];
    lh_r    <= dsig_r[26:0] * isig[52:27];
    ll_r    <= dsig_r[26:0] * isig[26:0];
    pe5_r   <= de_r + iexp;
    sgn5_r  <= sgn4_r;
    zero5_r <= zero4_r;
  end

  // stage 6: sum partial products
  logic [53:0]             mid;
  logic [105:0]            prod_r;
  logic signed [EXP_W-1:0] pe6_r;
  logic                    sgn6_r, zero6_r;

  assign mid = {1'b0, hl_r} + {1'b0, lh_r};

  always_ff @(posedge clk) begin
    prod_r  <= {hh_r, 54'd0} + {25'd0, mid, 27'd0} + {52'd0, ll_r};
    pe6_r   <= pe5_r;
    sgn6_r  <= sgn5_r;
    zero6_r <= zero5_r;
  end

  // stage 7: round product, scale by 1024
  logic [52:0]             pk;
  logic                    pg, pst, up7;
  logic [53:0]             rp;
  logic signed [EXP_W-1:0] pexp;
  logic [52:0]             zsig_r;
  logic signed [EXP_W-1:0] ve_r;
  logic                    sgn7_r, zero7_r;

  always_comb begin
    if (prod_r[105]) begin
      pk   = prod_r[105:53];
      pg   = prod_r[52];
      pst  = |prod_r[51:0];
      pexp = pe6_r + 12'sd53;
    end else begin
      pk   = prod_r[104:52];
      pg   = prod_r[51];
      pst  = |prod_r[50:0];
      pexp = pe6_r + 12'sd52;
    end
    up7 = pg & (pst | pk[0]);
    rp  = {1'b0, pk} + {53'd0, up7};
  end

  always_ff @(posedge clk) begin
    zsig_r  <= rp[53] ? {1'b1, 52'd0} : rp[52:0];
    ve_r    <= (rp[53] ? pexp + 12'sd1 : pexp) + 12'sd10;
    sgn7_r  <= sgn6_r;
    zero7_r <= zero6_r;
  end

  // stage 8: split integer and fraction
  logic signed [EXP_W-1:0] s_full;
  logic [5:0]              s8;
  logic [106:0]            w8;
  logic [52:0]             ip_r;
  logic                    half_r, stk_r, big_r, sgn8_r, zero8_r;

  always_comb begin
    s_full = 12'sd0 - ve_r;
    s8     = (s_full > 12'sd63) ? 6'd63 : s_full[5:0];
    w8     = {zsig_r, 54'd0} >> s8;
  end

  always_ff @(posedge clk) begin
    ip_r    <= w8[106:54];
    half_r  <= w8[53];
    stk_r   <= |w8[52:0];
    big_r   <= (ve_r >= 12'sd0);
    sgn8_r  <= sgn7_r;
    zero8_r <= zero7_r;
  end

  // stage 9: round half even and saturate
  logic [53:0]           ri;
  logic [Q_W-1:0]        qv;
  logic signed [Q_W-1:0] q_r;
  localparam logic [Q_W-1:0] Q_POS = 16'h7FFF;
  localparam logic [Q_W-1:0] Q_NEG = 16'h8000;

  always_comb begin
    ri = {1'b0, ip_r} + {53'd0, half_r & (stk_r | ip_r[0])};
    if (s8_r.cls == CLS_NAN) qv = '0;
    else if (s8_r.cls == CLS_INF) qv = s8_r.xs ? Q_NEG : Q_POS;
    else if (zero8_r) qv = '0;
    else if (big_r) qv = sgn8_r ? Q_NEG : Q_POS;
    else if (!sgn8_r) qv = (ri > 54'd32767) ? Q_POS : ri[15:0];
    else qv = (ri > 54'd32768) ? Q_NEG : (~ri[15:0]) + 16'd1;
  end

  always_ff @(posedge clk) begin
    q_r <= $signed(qv);
  end

  // sideband
  side_t s0;
  assign s0 = '{valid: in_valid, idx: in_idx, cls: in_cls, xs: in_raw[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0; s2_r <= '0; s3_r <= '0; s4_r <= '0;
      s5_r <= '0; s6_r <= '0; s7_r <= '0; s8_r <= '0;
    end else begin
      s1_r <= s0;   s2_r <= s1_r; s3_r <= s2_r; s4_r <= s3_r;
      s5_r <= s4_r; s6_r <= s5_r; s7_r <= s6_r; s8_r <= s7_r;
    end
  end

  side_t s9_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s9_r <= '0;
    else s9_r <= s8_r;
  end

  assign out_valid = s9_r.valid;
  assign out_idx   = s9_r.idx;
  assign out_q     = q_r;

endmodule
`default_nettype wire

@@ sv/zsq_back.sv @@
`default_nettype none
`include "zscore_q6p10_quantizer_unit_macros.svh"
module zsq_back #(
  parameter int FEATURE_COUNT = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire zsq_pkg::item_t            head,
  output logic                           pop,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [zsq_pkg::OUT_W-1:0]      out_tdata
);
  import zsq_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(FEATURE_COUNT - 1);

  logic [2:0]  j_r, j_nxt;
  logic [2:0]  used_r, used_nxt;
  logic [2:0]  ocnt_r, ocnt_nxt;
  logic [1:0]  wptr_r, rptr_r;
  logic        issue, start, push, drain;
  logic [RAW_W-1:0] raw;

  logic                  p_valid;
  logic [2:0]            p_idx;
  logic signed [Q_W-1:0] p_q;

  logic [Q_W-1:0] acc_r [NUM_SLOTS];
  logic [OUT_W-1:0] word;
  logic [OUT_W-1:0] omem [OUT_DEPTH];

  assign issue = head.valid && ((j_r != 3'd0) || (used_r < 3'(OUT_DEPTH)));
  assign start = issue && (j_r == 3'd0);
  assign pop   = issue && (j_r == LAST_IDX);
  assign raw   = head.data[{j_r, 5'd0} +: RAW_W];
  assign push  = p_valid && (p_idx == LAST_IDX);
  assign drain = out_tvalid && out_tready;

  always_comb begin
    j_nxt    = issue ? ((j_r == LAST_IDX) ? 3'd0 : j_r + 3'd1) : j_r;
    used_nxt = used_r + {2'd0, start} - {2'd0, drain};
    ocnt_nxt = ocnt_r + {2'd0, push} - {2'd0, drain};
  end

  zsq_fp_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue),
    .in_idx    (j_r),
    .in_raw    (raw),
    .in_cls    (head.cls[j_r]),
    .out_valid (p_valid),
    .out_idx   (p_idx),
    .out_q     (p_q)
  );

  always_ff @(posedge clk) begin
    if (p_valid) acc_r[p_idx] <= p_q;
  end

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (k >= FEATURE_COUNT) word[k*Q_W +: Q_W] = '0;
      else if (p_valid && p_idx == 3'(k)) word[k*Q_W +: Q_W] = p_q;
      else word[k*Q_W +: Q_W] = acc_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (push) omem[wptr_r] <= word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r    <= 3'd0;
      used_r <= 3'd0;
      ocnt_r <= 3'd0;
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
    end else begin
      j_r    <= j_nxt;
      used_r <= used_nxt;
      ocnt_r <= ocnt_nxt;
      if (push) wptr_r <= wptr_r + 2'd1;
      if (drain) rptr_r <= rptr_r + 2'd1;
    end
  end

  assign out_tvalid = (ocnt_r != 3'd0);
  assign out_tdata  = omem[rptr_r];

  `ZSQ_ASSERT_ALWAYS(a_credit_bound, used_r <= 3'(OUT_DEPTH), "credit count overrun")
  `ZSQ_ASSERT_ALWAYS(a_out_in_credit, ocnt_r <= used_r, "output entries exceed credits")
  `ZSQ_ASSERT_IMPL(a_no_overflow, push, (ocnt_r < 3'(OUT_DEPTH)) || drain, "output queue overflow")

endmodule
`default_nettype wire

@@ sv/zscore_q6p10_quantizer_unit.sv @@
// Z-score normalizer and Q6.10 quantizer for seven binary32 features.
// Input channel in_*: one transaction carries seven binary32 raw features.
// Output channel out_*: one transaction carries seven signed Q6.10 results.
// Each feature goes through one shared binary64 pipeline (subtract mean,
// multiply by inverse std-dev, scale, round half even, saturate).
// NaN gives 0, infinities saturate by sign.
// Throughput: the single pipeline takes one feature per cycle while
// issue is not stopped by the output queue limit described below.
// A two-entry input queue and a four-entry output queue decouple the sides;
// when out_tready is low the output queue fills, issue stops once four
// items are held or in flight, then the input queue fills and in_tready
// drops. No transaction is lost.
// Reset (rst_n low, synchronous) empties both queues and the pipeline.
`default_nettype none
module zscore_q6p10_quantizer_unit #(
  parameter int FEATURE_COUNT = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // raw_feature_0 .. raw_feature_6, 32 bits each
  input  wire logic [zsq_pkg::IN_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // quant_feature_0 .. quant_feature_6, 16 bits each
  output logic [zsq_pkg::OUT_W-1:0]        out_tdata
);
  import zsq_pkg::*;

  item_t head;
  logic  pop;

  zsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  zsq_back #(
    .FEATURE_COUNT (FEATURE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ dv/tb_zscore_q6p10_quantizer_unit.sv @@
`default_nettype none
module tb_zscore_q6p10_quantizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import zsq_pkg::*;

  localparam int N_RANDOM   = 930;
  localparam int TAIL_WAIT  = 40;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [IN_W-1:0]  raw_items [$];
  logic [OUT_W-1:0] quant_expected [$];
  int n_sent = 0;
  int n_fail = 0;
  int cycles = 0;
  int send_idle = 33;
  int recv_idle = 61;

  zscore_q6p10_quantizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // exact binary32 -> binary64 widening
  function automatic real widen_f32(input logic [31:0] raw);
    logic [10:0] e64;
    logic [51:0] m64;
    logic [63:0] sh;
    int p;
    p = 0;
    e64 = '0;
    m64 = '0;
    if (raw[30:23] == 8'hFF) begin
      e64 = 11'h7FF;
      m64 = {raw[22:0], 29'd0};
    end else if (raw[30:23] != 8'd0) begin
      e64 = 11'(int'(raw[30:23]) - 127 + 1023);
      m64 = {raw[22:0], 29'd0};
    end else if (raw[22:0] != 23'd0) begin
      for (int k = 0; k < 23; k++) if (raw[k]) p = k;
      e64 = 11'(p - 149 + 1023);
      sh = 64'(raw[22:0]) << (52 - p);
      m64 = sh[51:0];
    end
    return $bitstoreal({raw[31], e64, m64});
  endfunction

  function automatic logic [15:0] round_to_fixed(input real z);
    real v;
    real frac;
    longint t;
    longint fi;
    longint r;
    v = z * 1024.0;
    if (v != v) return 16'd0;
    if (v >= 32767.0) return 16'h7FFF;
    if (v <= -32768.0) return 16'h8000;
    t = longint'($rtoi(v));
    fi = t;
    if (v < 0.0 && real'(t) != v) fi = t - 1;
    frac = v - real'(fi);
    if (frac > 0.5) r = fi + 1;
    else if (frac < 0.5) r = fi;
    else r = fi[0] ? fi + 1 : fi;
    return r[15:0];
  endfunction

  function automatic logic [OUT_W-1:0] normalize_item(input logic [IN_W-1:0] raw);
    logic [OUT_W-1:0] q;
    real d;
    q = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      d = widen_f32(raw[32*j +: 32]) - $bitstoreal(MEAN_TAB[j]);
      q[16*j +: 16] = round_to_fixed(d * $bitstoreal(INV_SD_TAB[j]));
    end
    return q;
  endfunction

  // binary32 pattern near mean + z*sd, truncated; random bits if out of range
  function automatic logic [31:0] feature_at(input int j, input real z);
    logic [63:0] b;
    int e;
    b = $realtobits($bitstoreal(MEAN_TAB[j]) + z / $bitstoreal(INV_SD_TAB[j]));
    e = int'(b[62:52]) - 1023;
    if (e < -126 || e > 127) return $urandom;
    return {b[63], 8'(e + 127), b[51:29]};
  endfunction

  always @(posedge clk) begin
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (raw_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_tvalid <= 1'b1;
        in_tdata <= raw_items[0];
        quant_expected.push_back(normalize_item(raw_items[0]));
        void'(raw_items.pop_front());
        n_sent <= n_sent + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quant_expected.size() == 0) begin
        $error("unexpected output transaction %h", out_tdata);
        n_fail++;
      end else begin
        want = quant_expected.pop_front();
        for (int j = 0; j < NUM_SLOTS; j++)
          if (out_tdata[16*j +: 16] !== want[16*j +: 16]) begin
            $error("quant_feature_%0d expected %0d got %0d", j,
                   $signed(want[16*j +: 16]), $signed(out_tdata[16*j +: 16]));
            n_fail++;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (n_sent >= 2 * (N_RANDOM + 20) / 3) begin
      send_idle <= 0;
      recv_idle <= 0;
    end else if (n_sent >= (N_RANDOM + 20) / 3) begin
      send_idle <= 61;
      recv_idle <= 33;
    end
  end

  task automatic add_item(input logic [31:0] f [NUM_SLOTS]);
    logic [IN_W-1:0] it;
    for (int j = 0; j < NUM_SLOTS; j++) it[32*j +: 32] = f[j];
    raw_items.push_back(it);
  endtask

  task automatic add_same(input logic [31:0] v);
    logic [31:0] f [NUM_SLOTS];
    for (int j = 0; j < NUM_SLOTS; j++) f[j] = v;
    add_item(f);
  endtask

  task automatic add_random_item();
    logic [31:0] f [NUM_SLOTS];
    int mode;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      mode = $urandom_range(9);
      if (mode < 6)
        f[j] = feature_at(j, (real'($urandom_range(8000)) - 4000.0) / 1000.0);
      else if (mode < 8)
        f[j] = feature_at(j, (real'($urandom_range(80000)) - 40000.0) / 1000.0);
      else
        f[j] = $urandom;
    end
    add_item(f);
  endtask

  task automatic drain();
    while (raw_items.size() > 0 || in_tvalid || quant_expected.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] f [NUM_SLOTS];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    add_same(32'h0000_0000);
    add_same(32'h8000_0000);
    add_same(32'h7F80_0000);
    add_same(32'hFF80_0000);
    add_same(32'h7FC0_0000);
    add_same(32'hFFFF_FFFF);
    add_same(32'h7F80_0001);
    add_same(32'h7F7F_FFFF);
    add_same(32'hFF7F_FFFF);
    add_same(32'h0000_0001);
    add_same(32'h8040_0000);
    add_same(32'h007F_FFFF);
    add_same(32'h3F80_0000);
    add_same(32'hBF80_0000);
    for (int j = 0; j < NUM_SLOTS; j++) f[j] = feature_at(j, 0.0);
    add_item(f);
    for (int j = 0; j < NUM_SLOTS; j++) f[j] = feature_at(j, 31.99);
    add_item(f);
    for (int j = 0; j < NUM_SLOTS; j++) f[j] = feature_at(j, -32.01);
    add_item(f);
    for (int j = 0; j < NUM_SLOTS; j++) f[j] = feature_at(j, 33.0);
    add_item(f);
    for (int j = 0; j < NUM_SLOTS; j++) f[j] = feature_at(j, -1.0 / 2048.0);
    add_item(f);
    add_same(32'h5555_5555);
    for (int i = 0; i < N_RANDOM / 2; i++) add_random_item();
    drain();
    for (int i = N_RANDOM / 2; i < N_RANDOM; i++) add_random_item();
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_fail == 0 && quant_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
